>>> rtl/core/wiv_pkg.sv
package wiv_pkg;

    // apb register map
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_MIN_WINDOW_FILL  = 3'd0;
    localparam logic [2:0] REG_MAX_LOST_AGE     = 3'd1;
    localparam logic [2:0] REG_MIN_VOTE_COUNT   = 3'd2;
    localparam logic [2:0] REG_MIN_SUMMED_SCORE = 3'd3;
    localparam logic [2:0] REG_MIN_PEAK_SCORE   = 3'd4;

    localparam logic [7:0] LOST_AGE_MAX = 8'hFF;

    typedef enum logic [1:0] {
        PS_NONE    = 2'd0,
        PS_UNKNOWN = 2'd1,
        PS_KNOWN   = 2'd2
    } t_pstate;

    typedef struct packed {
        t_pstate     pstate;
        logic [15:0] id;
        logic [15:0] score;
    } t_verdict;

    localparam t_verdict VERDICT_NONE = '{pstate: PS_NONE, id: 16'd0, score: 16'd0};

    // window entry: key 0 is the unknown class, id + 1 otherwise
    typedef struct packed {
        logic [16:0] key;
        logic [15:0] score;
    } t_entry;

    typedef struct packed {
        logic [4:0]  min_window_fill;
        logic [7:0]  max_lost_age;
        logic [4:0]  min_vote_count;
        logic [19:0] min_summed_score;
        logic [15:0] min_peak_score;
    } t_cfg;

    // what an accepted item asks for
    typedef enum logic [1:0] {
        MODE_LOST   = 2'd0,
        MODE_IGNORE = 2'd1,
        MODE_SHORT  = 2'd2,
        MODE_VOTE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RD_OUTER = 2'd0,
        RD_FIRST = 2'd1,
        RD_NEXT  = 2'd2
    } t_rd_src;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_OUTER  = 3'd1,
        ST_KEY    = 3'd2,
        ST_INNER  = 3'd3,
        ST_BEST   = 3'd4,
        ST_FINISH = 3'd5
    } t_state;

    typedef struct packed {
        logic    accept;
        t_rd_src rd_src;
        logic    load_key;
        logic    acc;
        logic    pick;
        logic    commit;
    } t_cmd;

    typedef struct packed {
        t_mode in_mode;
        logic  j_last;
        logic  i_last;
        logic  out_free;
    } t_sts;

endpackage

>>> rtl/core/windowed_identity_vote.sv
// Identity voting over a sliding window of per-frame recognition results.
// Each accepted item (a lost tick or a recognition result) gives exactly one
// result item on the output channel, held in an output register so the next
// item can be taken while a result waits. A lost tick, a result that arrives
// while a decision is latched, and a result that leaves the window below the
// vote fill go from accept straight to the finish state, where the result is
// registered once the output register is free. A result that runs a vote
// takes each entry in turn as a candidate class (fetch, key load, compares,
// best update), F being the window fill after the new entry, and compares
// it against all F entries through the single read port of the window
// memory, one entry per cycle. Items are handled one at a time; stall
// stays high until the result is registered. Thresholds are set through the
// APB port at byte addresses 0x00 to 0x10 and must be written only while the
// block is idle.
module windowed_identity_vote #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_req_type,
    input  logic                       i_matched,
    input  logic [15:0]                i_person_id,
    input  logic [15:0]                i_match_score,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_person_state,
    output logic [15:0]                o_result_id,
    output logic [15:0]                o_result_score,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wiv_pkg::APB_AW-1:0] paddr,
    input  logic [wiv_pkg::APB_DW-1:0] pwdata,
    output logic [wiv_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    wiv_pkg::t_cfg     r_cfg;
    wiv_pkg::t_cmd     cmd;
    wiv_pkg::t_sts     sts;
    wiv_pkg::t_verdict verdict;
    logic [2:0]        reg_idx;
    logic              cfg_wr;

    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_window_fill  <= 5'd3;
            r_cfg.max_lost_age     <= 8'd5;
            r_cfg.min_vote_count   <= 5'd3;
            r_cfg.min_summed_score <= 20'd131072;
            r_cfg.min_peak_score   <= 16'd39321;
        end else if (cfg_wr) begin
            case (reg_idx)
                wiv_pkg::REG_MIN_WINDOW_FILL:  r_cfg.min_window_fill  <= pwdata[4:0];
                wiv_pkg::REG_MAX_LOST_AGE:     r_cfg.max_lost_age     <= pwdata[7:0];
                wiv_pkg::REG_MIN_VOTE_COUNT:   r_cfg.min_vote_count   <= pwdata[4:0];
                wiv_pkg::REG_MIN_SUMMED_SCORE: r_cfg.min_summed_score <= pwdata[19:0];
                wiv_pkg::REG_MIN_PEAK_SCORE:   r_cfg.min_peak_score   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            wiv_pkg::REG_MIN_WINDOW_FILL:  prdata = 32'(r_cfg.min_window_fill);
            wiv_pkg::REG_MAX_LOST_AGE:     prdata = 32'(r_cfg.max_lost_age);
            wiv_pkg::REG_MIN_VOTE_COUNT:   prdata = 32'(r_cfg.min_vote_count);
            wiv_pkg::REG_MIN_SUMMED_SCORE: prdata = 32'(r_cfg.min_summed_score);
            wiv_pkg::REG_MIN_PEAK_SCORE:   prdata = 32'(r_cfg.min_peak_score);
            default:                       prdata = '0;
        endcase
    end

    // sequencer
    wiv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // window, vote and result datapath
    wiv_dp #(
        .DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg         (r_cfg),
        .i_req_type    (i_req_type),
        .i_matched     (i_matched),
        .i_person_id   (i_person_id),
        .i_match_score (i_match_score),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_verdict     (verdict)
    );

    assign o_person_state = verdict.pstate;
    assign o_result_id    = verdict.id;
    assign o_result_score = verdict.score;

endmodule

>>> rtl/core/wiv_ctrl.sv
module wiv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  wiv_pkg::t_sts i_sts,
    output wiv_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    wiv_pkg::t_state r_state;
    wiv_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wiv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wiv_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_mode == wiv_pkg::MODE_VOTE) begin
                        n_state = wiv_pkg::ST_OUTER;
                    end else begin
                        n_state = wiv_pkg::ST_FINISH;
                    end
                end
            end
            wiv_pkg::ST_OUTER: begin
                n_state = wiv_pkg::ST_KEY;
            end
            wiv_pkg::ST_KEY: begin
                n_state = wiv_pkg::ST_INNER;
            end
            wiv_pkg::ST_INNER: begin
                if (i_sts.j_last) begin
                    n_state = wiv_pkg::ST_BEST;
                end
            end
            wiv_pkg::ST_BEST: begin
                if (i_sts.i_last) begin
                    n_state = wiv_pkg::ST_FINISH;
                end else begin
                    n_state = wiv_pkg::ST_OUTER;
                end
            end
            wiv_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = wiv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wiv_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_src = wiv_pkg::RD_OUTER;
        o_in_stall   = 1'b1;
        case (r_state)
            wiv_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            wiv_pkg::ST_OUTER: begin
                o_cmd.rd_src = wiv_pkg::RD_OUTER;
            end
            wiv_pkg::ST_KEY: begin
                o_cmd.rd_src   = wiv_pkg::RD_FIRST;
                o_cmd.load_key = 1'b1;
            end
            wiv_pkg::ST_INNER: begin
                o_cmd.rd_src = wiv_pkg::RD_NEXT;
                o_cmd.acc    = 1'b1;
            end
            wiv_pkg::ST_BEST: begin
                o_cmd.pick = 1'b1;
            end
            wiv_pkg::ST_FINISH: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/wiv_dp.sv
module wiv_dp #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wiv_pkg::t_cmd     i_cmd,
    output wiv_pkg::t_sts     o_sts,
    input  wiv_pkg::t_cfg     i_cfg,
    input  logic              i_req_type,
    input  logic              i_matched,
    input  logic [15:0]       i_person_id,
    input  logic [15:0]       i_match_score,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output wiv_pkg::t_verdict o_verdict
);

    localparam int HW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = 16 + CW;
    localparam int SCW  = (SW > 20) ? SW : 20;
    localparam logic [HW-1:0] HEAD_LAST = HW'(DEPTH - 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(DEPTH);

    // window store
    wiv_pkg::t_entry r_mem [DEPTH];
    wiv_pkg::t_entry r_rd;
    logic [HW-1:0]   rd_addr;
    logic            wr_en;
    wiv_pkg::t_entry wr_entry;

    // block state
    logic [CW-1:0]     r_fill;
    logic [HW-1:0]     r_head;
    logic [7:0]        r_lost_age;
    logic              r_decided;
    wiv_pkg::t_verdict r_latched;
    wiv_pkg::t_verdict r_last;
    logic              r_out_valid;
    wiv_pkg::t_verdict r_out;
    wiv_pkg::t_mode    r_mode;

    // vote loop registers
    logic [HW-1:0] r_i;
    logic [HW-1:0] r_j;
    logic [16:0]   r_key;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_sum;
    logic [15:0]   r_peak;
    logic [CW-1:0] r_best_cnt;
    logic [16:0]   r_best_key;
    logic [SW-1:0] r_best_sum;
    logic [15:0]   r_best_peak;

    wiv_pkg::t_mode    in_mode;
    wiv_pkg::t_verdict fin;
    logic              lost_clear;
    logic              set_latch;
    logic              vote_pass;
    logic              better;
    logic [CW-1:0]     fill_last;

    // classify the offered item
    always_comb begin
        if (!i_req_type) begin
            in_mode = wiv_pkg::MODE_LOST;
        end else if (r_decided) begin
            in_mode = wiv_pkg::MODE_IGNORE;
        end else if ((8'(r_fill) + 8'd1) < 8'(i_cfg.min_window_fill)) begin
            in_mode = wiv_pkg::MODE_SHORT;
        end else begin
            in_mode = wiv_pkg::MODE_VOTE;
        end
    end

    assign wr_en = i_cmd.accept &&
                   (in_mode == wiv_pkg::MODE_SHORT || in_mode == wiv_pkg::MODE_VOTE);
    assign wr_entry.key   = i_matched ? (17'(i_person_id) + 17'd1) : 17'd0;
    assign wr_entry.score = i_match_score;

    // read address select
    always_comb begin
        case (i_cmd.rd_src)
            wiv_pkg::RD_OUTER: rd_addr = r_i;
            wiv_pkg::RD_FIRST: rd_addr = '0;
            wiv_pkg::RD_NEXT:  rd_addr = r_j + HW'(1);
            default:           rd_addr = '0;
        endcase
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_head] <= wr_entry;
        end
        r_rd <= r_mem[rd_addr];
    end

    // loop status
    assign fill_last      = r_fill - CW'(1);
    assign o_sts.in_mode  = in_mode;
    assign o_sts.j_last   = (CW'(r_j) == fill_last);
    assign o_sts.i_last   = (CW'(r_i) == fill_last);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign better = (r_cnt > r_best_cnt) || (r_cnt == r_best_cnt && r_key < r_best_key);

    // vote thresholds on the winning class
    assign vote_pass = (8'(r_best_cnt) >= 8'(i_cfg.min_vote_count)) &&
                       (SCW'(r_best_sum) >= SCW'(i_cfg.min_summed_score)) &&
                       (r_best_peak >= i_cfg.min_peak_score);

    assign lost_clear = (r_lost_age >= i_cfg.max_lost_age);

    // result of the item in flight
    always_comb begin
        fin       = r_latched;
        set_latch = 1'b0;
        case (r_mode)
            wiv_pkg::MODE_LOST: begin
                fin = lost_clear ? wiv_pkg::VERDICT_NONE : r_latched;
            end
            wiv_pkg::MODE_IGNORE: begin
                fin = r_last;
            end
            wiv_pkg::MODE_SHORT: begin
                fin = wiv_pkg::VERDICT_NONE;
            end
            wiv_pkg::MODE_VOTE: begin
                if (vote_pass) begin
                    set_latch = 1'b1;
                    if (r_best_key == 17'd0) begin
                        fin.pstate = wiv_pkg::PS_UNKNOWN;
                        fin.id     = 16'd0;
                    end else begin
                        fin.pstate = wiv_pkg::PS_KNOWN;
                        fin.id     = 16'(r_best_key - 17'd1);
                    end
                    fin.score = r_best_peak;
                end else if (r_fill == FILL_FULL) begin
                    set_latch  = 1'b1;
                    fin.pstate = wiv_pkg::PS_UNKNOWN;
                    fin.id     = 16'd0;
                    fin.score  = 16'd0;
                end
            end
            default: begin
                fin = r_latched;
            end
        endcase
    end

    // window bookkeeping, decision and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_head      <= '0;
            r_lost_age  <= 8'd0;
            r_decided   <= 1'b0;
            r_latched   <= wiv_pkg::VERDICT_NONE;
            r_last      <= wiv_pkg::VERDICT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_head     <= (r_head == HEAD_LAST) ? '0 : r_head + HW'(1);
                r_fill     <= (r_fill == FILL_FULL) ? r_fill : r_fill + CW'(1);
                r_lost_age <= 8'd0;
            end
            if (i_cmd.commit) begin
                r_last      <= fin;
                r_out_valid <= 1'b1;
                if (r_mode == wiv_pkg::MODE_LOST) begin
                    if (lost_clear) begin
                        r_fill    <= '0;
                        r_head    <= '0;
                        r_latched <= wiv_pkg::VERDICT_NONE;
                    end
                    if (r_lost_age != wiv_pkg::LOST_AGE_MAX) begin
                        r_lost_age <= r_lost_age + 8'd1;
                    end
                    r_decided <= 1'b0;
                end
                if (set_latch) begin
                    r_decided <= 1'b1;
                    r_latched <= fin;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload side: mode, vote loop, result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode      <= in_mode;
            r_i         <= '0;
            r_best_cnt  <= '0;
            r_best_key  <= 17'd0;
            r_best_sum  <= '0;
            r_best_peak <= 16'd0;
        end
        if (i_cmd.load_key) begin
            r_key  <= r_rd.key;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_peak <= 16'd0;
            r_j    <= '0;
        end
        if (i_cmd.acc) begin
            if (r_rd.key == r_key) begin
                r_cnt <= r_cnt + CW'(1);
                r_sum <= r_sum + SW'(r_rd.score);
                if (r_rd.score > r_peak) begin
                    r_peak <= r_rd.score;
                end
            end
            r_j <= r_j + HW'(1);
        end
        if (i_cmd.pick) begin
            if (better) begin
                r_best_cnt  <= r_cnt;
                r_best_key  <= r_key;
                r_best_sum  <= r_sum;
                r_best_peak <= r_peak;
            end
            r_i <= r_i + HW'(1);
        end
        if (i_cmd.commit) begin
            r_out <= fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out;

endmodule
